// ===== src/asa_pkg.sv =====
// ----------------------------------------------------------------------------
// asa_pkg: shared types and constants of the aligned stack allocator
// Sizes of the region arithmetic and the allocation stack, status codes,
// the stack memory interface and the header padding function.
// ----------------------------------------------------------------------------
package asa_pkg;

   localparam int STACK_DEPTH    = 256;
   localparam int HEADER_BYTES   = 8;
   localparam int ADDR_BITS      = 32;

   localparam int SLOT_BITS      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int COUNT_BITS     = $clog2(STACK_DEPTH + 1);
   localparam int SIZE_BITS      = 32;
   localparam int ALIGN_BITS     = 8;
   localparam int PAD_BITS       = 8;
   localparam int STATUS_BITS    = 3;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_BASE_ADDRESS   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAPACITY_BYTES = CSR_INDEX_BITS'(1);

   localparam logic [ADDR_BITS-1:0] BASE_RESET     = '0;
   localparam logic [SIZE_BITS-1:0] CAPACITY_RESET = SIZE_BITS'(65536);

   localparam logic KIND_ALLOC   = 1'b0;
   localparam logic KIND_DEALLOC = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK        = 3'd0,
      ST_NO_SPACE  = 3'd1,
      ST_ZERO_SIZE = 3'd2,
      ST_FULL      = 3'd3,
      ST_EMPTY     = 3'd4,
      ST_NOT_TOP   = 3'd5,
      ST_BAD_ALIGN = 3'd6
   } status_type;

   // one stack entry: padding before the block and its aligned address
   typedef struct packed {
      logic [PAD_BITS-1:0]  pad;
      logic [ADDR_BITS-1:0] addr;
   } stack_entry_type;

   // one access word to the stack memory
   typedef struct packed {
      logic                 rd_en;
      logic [SLOT_BITS-1:0] rd_slot;
      logic                 wr_en;
      logic [SLOT_BITS-1:0] wr_slot;
      stack_entry_type      wr_entry;
   } stack_req_type;

   // Padding from the top pointer to the first aligned address that leaves
   // at least HEADER_BYTES below it. align must be a power of two.
   function automatic logic [PAD_BITS-1:0] header_adjust(
      input logic [ALIGN_BITS-1:0] top_low,
      input logic [ALIGN_BITS-1:0] align);
      logic [ALIGN_BITS-1:0] mask;
      logic [ALIGN_BITS-1:0] mis;
      logic [ALIGN_BITS:0]   adj0;
      logic [ALIGN_BITS:0]   need;
      logic [ALIGN_BITS:0]   round_up;
      logic [ALIGN_BITS+1:0] adj;
      mask     = align - ALIGN_BITS'(1);
      mis      = top_low & mask;
      adj0     = (mis != '0) ? ({1'b0, align} - {1'b0, mis}) : '0;
      need     = (ALIGN_BITS+1)'(HEADER_BYTES) - adj0;
      round_up = (need + {1'b0, mask}) & ~{1'b0, mask};
      if (adj0 < (ALIGN_BITS+1)'(HEADER_BYTES)) begin
         adj = {1'b0, adj0} + {1'b0, round_up};
      end else begin
         adj = {1'b0, adj0};
      end
      return adj[PAD_BITS-1:0];
   endfunction

endpackage

// ===== src/aligned_stack_allocator_core.sv =====
// ----------------------------------------------------------------------------
// aligned_stack_allocator_core: LIFO bump allocator with header padding
// Allocates aligned blocks from a region and frees them in reverse order.
// ----------------------------------------------------------------------------
// For each request, the cycle in which start is taken reads the top slot of
// the allocation stack memory, and the next cycle checks the request,
// updates the top pointer, used count and block count and pushes the new
// entry. busy is high during that execute cycle, so no new request is taken
// until it ends. The response word appears in the cycle after the execute
// cycle, for exactly one cycle with rsp_valid high; it cannot be held off, so
// capture it when rsp_valid is seen. Stack entries need no clearing after
// reset. Configuration writes belong to idle periods; writing base_address
// empties the allocator.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_core (
   input  logic                                   clock,
   input  logic                                   reset,
   // request word
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_kind,
   input  logic [asa_pkg::SIZE_BITS-1:0]          req_request_bytes,
   input  logic [asa_pkg::ALIGN_BITS-1:0]         req_align_bytes,
   input  logic [asa_pkg::ADDR_BITS-1:0]          req_free_address,
   // response word
   output logic                                   rsp_valid,
   output logic [asa_pkg::ADDR_BITS-1:0]          rsp_block_address,
   output logic [asa_pkg::STATUS_BITS-1:0]        rsp_status,
   output logic [asa_pkg::SIZE_BITS-1:0]          rsp_bytes_used,
   output logic [asa_pkg::COUNT_BITS-1:0]         rsp_live_blocks,
   // register writes
   input  logic                                   csr_write_enable,
   input  logic [asa_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [asa_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_EXEC = 2'b10
   } fsm_type;

   localparam int SUM_BITS = asa_pkg::SIZE_BITS + 2;

   fsm_type                              fsm_ff, fsm_in;
   logic [asa_pkg::ADDR_BITS-1:0]        top_ff, top_in;
   logic [asa_pkg::SIZE_BITS-1:0]        used_ff, used_in;
   logic [asa_pkg::COUNT_BITS-1:0]       count_ff, count_in;
   logic [asa_pkg::SIZE_BITS-1:0]        capacity_ff;

   // latched request word
   logic                                 kind_ff;
   logic [asa_pkg::SIZE_BITS-1:0]        size_ff;
   logic [asa_pkg::ALIGN_BITS-1:0]       align_ff;
   logic [asa_pkg::ADDR_BITS-1:0]        free_ff;

   // response registers
   logic                                 rsp_valid_ff;
   logic [asa_pkg::ADDR_BITS-1:0]        rsp_addr_ff, rsp_addr_in;
   asa_pkg::status_type                  rsp_status_ff, rsp_status_in;
   logic [asa_pkg::SIZE_BITS-1:0]        rsp_used_ff;
   logic [asa_pkg::COUNT_BITS-1:0]       rsp_count_ff;

   logic                                 accept;
   logic                                 exec;
   logic [asa_pkg::COUNT_BITS-1:0]       count_dec;
   asa_pkg::stack_req_type               stack_req;
   asa_pkg::stack_entry_type             top_entry;

   logic [asa_pkg::PAD_BITS-1:0]         adj;
   logic [asa_pkg::ADDR_BITS-1:0]        aligned;
   logic [SUM_BITS-1:0]                  need_total;
   logic [asa_pkg::ALIGN_BITS-1:0]       align_low;
   logic [asa_pkg::ADDR_BITS-1:0]        span;
   logic                                 push;

   assign accept    = start && (fsm_ff == FSM_IDLE);
   assign exec      = (fsm_ff == FSM_EXEC);
   assign busy      = exec;
   assign count_dec = count_ff - asa_pkg::COUNT_BITS'(1);

   // stack memory: read the top slot on accept, push in the execute cycle
   asa_stack_mem u_stack (
      .clock    (clock),
      .req      (stack_req),
      .rd_entry (top_entry)
   );

   // alignment and capacity arithmetic
   always_comb begin
      align_low  = align_ff - asa_pkg::ALIGN_BITS'(1);
      adj        = asa_pkg::header_adjust(top_ff[asa_pkg::ALIGN_BITS-1:0], align_ff);
      aligned    = top_ff + asa_pkg::ADDR_BITS'(adj);
      need_total = SUM_BITS'(used_ff) + SUM_BITS'(adj) + SUM_BITS'(size_ff);
      span       = top_ff - top_entry.addr;
   end

   // decide status and next state of the allocator
   always_comb begin
      fsm_in        = fsm_ff;
      top_in        = top_ff;
      used_in       = used_ff;
      count_in      = count_ff;
      rsp_addr_in   = '0;
      rsp_status_in = asa_pkg::ST_OK;
      push          = 1'b0;

      case (fsm_ff)
         FSM_IDLE: begin
            if (start) begin
               fsm_in = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            fsm_in = FSM_IDLE;
            if (kind_ff == asa_pkg::KIND_ALLOC) begin
               if (size_ff == '0) begin
                  rsp_status_in = asa_pkg::ST_ZERO_SIZE;
               end else if (align_ff == '0 || (align_ff & align_low) != '0) begin
                  rsp_status_in = asa_pkg::ST_BAD_ALIGN;
               end else if (count_ff >= asa_pkg::COUNT_BITS'(asa_pkg::STACK_DEPTH)) begin
                  rsp_status_in = asa_pkg::ST_FULL;
               end else if (need_total > SUM_BITS'(capacity_ff)) begin
                  rsp_status_in = asa_pkg::ST_NO_SPACE;
               end else begin
                  push        = 1'b1;
                  rsp_addr_in = aligned;
                  top_in      = aligned + size_ff;
                  used_in     = need_total[asa_pkg::SIZE_BITS-1:0];
                  count_in    = count_ff + asa_pkg::COUNT_BITS'(1);
               end
            end else begin
               if (count_ff == '0) begin
                  rsp_status_in = asa_pkg::ST_EMPTY;
               end else if (free_ff != top_entry.addr) begin
                  rsp_status_in = asa_pkg::ST_NOT_TOP;
               end else begin
                  used_in  = used_ff - span - asa_pkg::SIZE_BITS'(top_entry.pad);
                  top_in   = top_entry.addr - asa_pkg::ADDR_BITS'(top_entry.pad);
                  count_in = count_dec;
               end
            end
         end
         default: begin
            fsm_in = FSM_IDLE;
         end
      endcase
   end

   // build the stack access word
   always_comb begin
      stack_req.rd_en          = accept;
      stack_req.rd_slot        = count_dec[asa_pkg::SLOT_BITS-1:0];
      stack_req.wr_en          = push;
      stack_req.wr_slot        = count_ff[asa_pkg::SLOT_BITS-1:0];
      stack_req.wr_entry.pad   = adj;
      stack_req.wr_entry.addr  = aligned;
   end

   // control state, allocator state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         top_ff       <= asa_pkg::BASE_RESET;
         used_ff      <= '0;
         count_ff     <= '0;
         capacity_ff  <= asa_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= exec;
         if (csr_write_enable && csr_index == asa_pkg::CSR_BASE_ADDRESS) begin
            // new base empties the allocator
            top_ff   <= csr_write_data[asa_pkg::ADDR_BITS-1:0];
            used_ff  <= '0;
            count_ff <= '0;
         end else begin
            top_ff   <= top_in;
            used_ff  <= used_in;
            count_ff <= count_in;
         end
         if (csr_write_enable && csr_index == asa_pkg::CSR_CAPACITY_BYTES) begin
            capacity_ff <= csr_write_data[asa_pkg::SIZE_BITS-1:0];
         end
      end
   end

   // hold the request word for the execute cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= req_kind;
         size_ff  <= req_request_bytes;
         align_ff <= req_align_bytes;
         free_ff  <= req_free_address;
      end
   end

   // capture the response word
   always_ff @(posedge clock) begin
      if (exec) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_status_ff <= rsp_status_in;
         rsp_used_ff   <= used_in;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_block_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_bytes_used    = rsp_used_ff;
   assign rsp_live_blocks   = rsp_count_ff;

endmodule

// ===== src/asa_stack_mem.sv =====
// ----------------------------------------------------------------------------
// asa_stack_mem: allocation stack storage
// One synchronous memory holding padding and aligned address per slot.
// One write and one read per cycle, read data valid in the cycle after rd_en.
// ----------------------------------------------------------------------------
module asa_stack_mem (
   input  logic                     clock,
   input  asa_pkg::stack_req_type   req,
   output asa_pkg::stack_entry_type rd_entry
);

   asa_pkg::stack_entry_type mem_ff [asa_pkg::STACK_DEPTH];
   asa_pkg::stack_entry_type rd_entry_ff;

   // write the pushed entry
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem_ff[req.wr_slot] <= req.wr_entry;
      end
   end

   // register the read word
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_entry_ff <= mem_ff[req.rd_slot];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

// ===== tb/sv/aligned_stack_allocator_core_tb.sv =====
// ----------------------------------------------------------------------------
// aligned_stack_allocator_core_tb: self-checking bench of the stack allocator
// Sends a short directed list, then random allocate and free traffic under
// several region settings. Every accepted request word is run through a
// behavioral allocator model in the bench, and each response word is checked
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PRINT_LIMIT = 100;

   // indexes past the register list, written to show they are ignored
   localparam logic [asa_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LOW  =
      asa_pkg::CSR_INDEX_BITS'(2);
   localparam logic [asa_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HIGH =
      asa_pkg::CSR_INDEX_BITS'(3);

   typedef struct packed {
      logic                           kind;
      logic [asa_pkg::SIZE_BITS-1:0]  size;
      logic [asa_pkg::ALIGN_BITS-1:0] align;
      logic [asa_pkg::ADDR_BITS-1:0]  free_addr;
   } req_word_type;

   typedef struct packed {
      logic [asa_pkg::ADDR_BITS-1:0]  block_address;
      asa_pkg::status_type            status;
      logic [asa_pkg::SIZE_BITS-1:0]  bytes_used;
      logic [asa_pkg::COUNT_BITS-1:0] live_blocks;
   } alloc_reply_type;

   // how a directed row fills in the fields that depend on allocator state
   typedef enum logic [1:0] {
      ROW_PLAIN,
      ROW_FREE_TOP,
      ROW_FILL
   } row_mode_type;

   typedef struct packed {
      row_mode_type    mode;
      req_word_type    word;
      logic            typed;
      alloc_reply_type reply;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic req_kind;
   logic [asa_pkg::SIZE_BITS-1:0] req_request_bytes;
   logic [asa_pkg::ALIGN_BITS-1:0] req_align_bytes;
   logic [asa_pkg::ADDR_BITS-1:0] req_free_address;
   logic rsp_valid;
   logic [asa_pkg::ADDR_BITS-1:0] rsp_block_address;
   logic [asa_pkg::STATUS_BITS-1:0] rsp_status;
   logic [asa_pkg::SIZE_BITS-1:0] rsp_bytes_used;
   logic [asa_pkg::COUNT_BITS-1:0] rsp_live_blocks;
   logic csr_write_enable;
   logic [asa_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [asa_pkg::CSR_DATA_BITS-1:0] csr_write_data;

   // bench copy of the allocator state
   logic [asa_pkg::SIZE_BITS-1:0] region_capacity;
   logic [asa_pkg::ADDR_BITS-1:0] top_ptr;
   logic [asa_pkg::SIZE_BITS-1:0] used_bytes;
   int                            live_count;
   logic [asa_pkg::PAD_BITS-1:0]  pad_mem  [asa_pkg::STACK_DEPTH];
   logic [asa_pkg::ADDR_BITS-1:0] addr_mem [asa_pkg::STACK_DEPTH];

   alloc_reply_type  expected_replies [$];
   directed_row_type directed_rows [$];

   // typed answer attached to the word on the request ports
   logic            typed_valid;
   alloc_reply_type typed_reply;

   bit idle_enable;
   int accept_count;
   int error_count;
   int cycle_count;

   aligned_stack_allocator_core uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_kind          (req_kind),
      .req_request_bytes (req_request_bytes),
      .req_align_bytes   (req_align_bytes),
      .req_free_address  (req_free_address),
      .rsp_valid         (rsp_valid),
      .rsp_block_address (rsp_block_address),
      .rsp_status        (rsp_status),
      .rsp_bytes_used    (rsp_bytes_used),
      .rsp_live_blocks   (rsp_live_blocks),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_failure(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      error_count++;
   endtask

   // Padding from the top pointer up to the first aligned address that has
   // room for the header below it.
   function automatic logic [asa_pkg::PAD_BITS-1:0] header_pad(
      input logic [asa_pkg::ADDR_BITS-1:0] top,
      input logic [asa_pkg::ALIGN_BITS-1:0] align);
      int unsigned a;
      int unsigned mis;
      int unsigned pad;
      int unsigned need;
      a   = 32'(align);
      mis = 32'(top[asa_pkg::ALIGN_BITS-1:0]) & (a - 1);
      pad = (mis != 0) ? a - mis : 0;
      if (pad < asa_pkg::HEADER_BYTES) begin
         need = asa_pkg::HEADER_BYTES - pad;
         pad  = pad + a * (need / a);
         if (need % a != 0) begin
            pad = pad + a;
         end
      end
      return pad[asa_pkg::PAD_BITS-1:0];
   endfunction

   // Apply one request word to the bench allocator and return its response.
   function automatic alloc_reply_type allocator_step(input req_word_type w);
      alloc_reply_type                r;
      logic [asa_pkg::PAD_BITS-1:0]   pad;
      logic [asa_pkg::SIZE_BITS+1:0]  total;
      logic [asa_pkg::ADDR_BITS-1:0]  aligned;
      logic [asa_pkg::ADDR_BITS-1:0]  span;
      r.block_address = '0;
      r.status        = asa_pkg::ST_OK;
      if (w.kind == asa_pkg::KIND_ALLOC) begin
         if (w.size == '0) begin
            r.status = asa_pkg::ST_ZERO_SIZE;
         end else if (w.align == '0 ||
                      (w.align & (w.align - asa_pkg::ALIGN_BITS'(1))) != '0) begin
            r.status = asa_pkg::ST_BAD_ALIGN;
         end else if (live_count >= asa_pkg::STACK_DEPTH) begin
            r.status = asa_pkg::ST_FULL;
         end else begin
            pad   = header_pad(top_ptr, w.align);
            total = {2'b00, used_bytes} + (asa_pkg::SIZE_BITS+2)'(pad) + {2'b00, w.size};
            if (total > {2'b00, region_capacity}) begin
               r.status = asa_pkg::ST_NO_SPACE;
            end else begin
               aligned              = top_ptr + asa_pkg::ADDR_BITS'(pad);
               pad_mem[live_count]  = pad;
               addr_mem[live_count] = aligned;
               top_ptr              = aligned + w.size;
               used_bytes           = total[asa_pkg::SIZE_BITS-1:0];
               live_count++;
               r.block_address = aligned;
            end
         end
      end else begin
         if (live_count == 0) begin
            r.status = asa_pkg::ST_EMPTY;
         end else if (w.free_addr != addr_mem[live_count-1]) begin
            r.status = asa_pkg::ST_NOT_TOP;
         end else begin
            span       = top_ptr - addr_mem[live_count-1];
            used_bytes = used_bytes - span - asa_pkg::SIZE_BITS'(pad_mem[live_count-1]);
            top_ptr    = addr_mem[live_count-1] -
                         asa_pkg::ADDR_BITS'(pad_mem[live_count-1]);
            live_count--;
         end
      end
      r.bytes_used  = used_bytes;
      r.live_blocks = asa_pkg::COUNT_BITS'(live_count);
      return r;
   endfunction

   // Check response words, then predict every request word taken this edge.
   always @(posedge clock) begin : reply_check
      alloc_reply_type want;
      alloc_reply_type got;
      req_word_type    w;
      if (!reset) begin
         if (rsp_valid) begin
            got.block_address = rsp_block_address;
            got.status        = asa_pkg::status_type'(rsp_status);
            got.bytes_used    = rsp_bytes_used;
            got.live_blocks   = rsp_live_blocks;
            if (expected_replies.size() == 0) begin
               report_failure($sformatf("response with nothing outstanding, status %0d",
                                        rsp_status));
            end else begin
               want = expected_replies.pop_front();
               if (got.block_address !== want.block_address)
                  report_failure($sformatf("block_address %h, want %h",
                                           got.block_address, want.block_address));
               if (got.status !== want.status)
                  report_failure($sformatf("status %0d, want %0d", got.status, want.status));
               if (got.bytes_used !== want.bytes_used)
                  report_failure($sformatf("bytes_used %h, want %h",
                                           got.bytes_used, want.bytes_used));
               if (got.live_blocks !== want.live_blocks)
                  report_failure($sformatf("live_blocks %0d, want %0d",
                                           got.live_blocks, want.live_blocks));
            end
         end
         if (start && !busy) begin
            w.kind      = req_kind;
            w.size      = req_request_bytes;
            w.align     = req_align_bytes;
            w.free_addr = req_free_address;
            want        = allocator_step(w);
            if (typed_valid) begin
               want = typed_reply;
            end
            expected_replies.push_back(want);
            accept_count++;
         end
      end
   end

   // Stop a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** aligned_stack_allocator_core: FAILED **");
         $finish;
      end
   end

   // Present one word at a falling edge and hold it until it is taken.
   task automatic send_word(input req_word_type w, input logic typed,
                            input alloc_reply_type reply);
      int seen;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_kind          = w.kind;
      req_request_bytes = w.size;
      req_align_bytes   = w.align;
      req_free_address  = w.free_addr;
      typed_valid       = typed;
      typed_reply       = reply;
      start             = 1'b1;
      seen              = accept_count;
      while (accept_count == seen) @(negedge clock);
   endtask

   // Drop start and wait until every response has come back.
   task automatic drain;
      start = 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [asa_pkg::CSR_INDEX_BITS-1:0] index,
                            input logic [asa_pkg::CSR_DATA_BITS-1:0] data);
      drain();
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (index == asa_pkg::CSR_BASE_ADDRESS) begin
         top_ptr     = data;
         used_bytes  = '0;
         live_count  = 0;
      end else if (index == asa_pkg::CSR_CAPACITY_BYTES) begin
         region_capacity = data;
      end
   endtask

   function automatic logic [asa_pkg::ADDR_BITS-1:0] newest_block;
      return (live_count > 0) ? addr_mem[live_count-1] : asa_pkg::ADDR_BITS'($urandom);
   endfunction

   // Mostly well-formed allocate and free words, with some noise.
   function automatic req_word_type pick_request;
      req_word_type w;
      int           r;
      r = $urandom_range(0, 99);
      w.free_addr = $urandom;
      if (r < 55) begin
         w.kind = asa_pkg::KIND_ALLOC;
         r      = $urandom_range(0, 99);
         if (r < 85)      w.size = $urandom_range(1, 64);
         else if (r < 95) w.size = $urandom_range(1, 4096);
         else             w.size = $urandom;
         w.align = asa_pkg::ALIGN_BITS'(1 << $urandom_range(0, 7));
      end else if (r < 90) begin
         w.kind      = asa_pkg::KIND_DEALLOC;
         w.size      = $urandom;
         w.align     = asa_pkg::ALIGN_BITS'($urandom_range(0, 255));
         w.free_addr = newest_block();
      end else begin
         w.kind  = 1'($urandom_range(0, 1));
         w.size  = ($urandom_range(0, 1) == 0) ? '0 : asa_pkg::SIZE_BITS'($urandom);
         w.align = asa_pkg::ALIGN_BITS'($urandom_range(0, 255));
         if (live_count > 0 && $urandom_range(0, 1) == 0) begin
            w.free_addr = addr_mem[live_count-1] ^
                          (asa_pkg::ADDR_BITS'(1) << $urandom_range(0, 31));
         end
      end
      return w;
   endfunction

   task automatic run_mixed(input int n_words);
      for (int k = 0; k < n_words; k++) begin
         send_word(pick_request(), 1'b0, '0);
      end
   endtask

   // Push past the stack depth with tiny blocks, then pop past empty.
   task automatic run_stack_fill;
      req_word_type w;
      for (int k = 0; k < asa_pkg::STACK_DEPTH + 6; k++) begin
         w.kind      = asa_pkg::KIND_ALLOC;
         w.size      = $urandom_range(1, 4);
         w.align     = asa_pkg::ALIGN_BITS'(1 << $urandom_range(0, 1));
         w.free_addr = $urandom;
         send_word(w, 1'b0, '0);
      end
      for (int k = 0; k < asa_pkg::STACK_DEPTH + 6; k++) begin
         w.kind      = asa_pkg::KIND_DEALLOC;
         w.size      = $urandom;
         w.align     = asa_pkg::ALIGN_BITS'($urandom_range(0, 255));
         w.free_addr = newest_block();
         send_word(w, 1'b0, '0);
      end
   endtask

   function automatic void add_row(input row_mode_type mode, input logic kind,
                                   input logic [asa_pkg::SIZE_BITS-1:0] size,
                                   input logic [asa_pkg::ALIGN_BITS-1:0] align,
                                   input logic [asa_pkg::ADDR_BITS-1:0] free_addr,
                                   input logic typed = 1'b0,
                                   input logic [asa_pkg::ADDR_BITS-1:0] blk = '0,
                                   input asa_pkg::status_type st = asa_pkg::ST_OK,
                                   input logic [asa_pkg::SIZE_BITS-1:0] used = '0,
                                   input logic [asa_pkg::COUNT_BITS-1:0] live = '0);
      directed_row_type row;
      row.mode                = mode;
      row.word.kind           = kind;
      row.word.size           = size;
      row.word.align          = align;
      row.word.free_addr      = free_addr;
      row.typed               = typed;
      row.reply.block_address = blk;
      row.reply.status        = st;
      row.reply.bytes_used    = used;
      row.reply.live_blocks   = live;
      directed_rows.push_back(row);
   endfunction

   initial begin : stimulus
      req_word_type w;
      reset            = 1'b1;
      start            = 1'b0;
      req_kind         = asa_pkg::KIND_ALLOC;
      req_request_bytes = '0;
      req_align_bytes  = '0;
      req_free_address = '0;
      csr_write_enable = 1'b0;
      csr_index        = asa_pkg::CSR_BASE_ADDRESS;
      csr_write_data   = '0;
      typed_valid      = 1'b0;
      typed_reply      = '0;
      idle_enable      = 1'b1;
      accept_count     = 0;
      error_count      = 0;
      cycle_count      = 0;
      region_capacity  = asa_pkg::CAPACITY_RESET;
      top_ptr          = asa_pkg::BASE_RESET;
      used_bytes       = '0;
      live_count       = 0;

      // errors from an empty allocator, one block in and out, then a 128-aligned block
      add_row(ROW_PLAIN, asa_pkg::KIND_DEALLOC, 32'd0, 8'd1, 32'd0, 1'b1, 32'd0,
              asa_pkg::ST_EMPTY, 32'd0, 9'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd0, 8'd8, 32'd0, 1'b1, 32'd0,
              asa_pkg::ST_ZERO_SIZE, 32'd0, 9'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd16, 8'd0, 32'd0, 1'b1, 32'd0,
              asa_pkg::ST_BAD_ALIGN, 32'd0, 9'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd16, 8'd3, 32'd0, 1'b1, 32'd0,
              asa_pkg::ST_BAD_ALIGN, 32'd0, 9'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd16, 8'hFF, 32'd0, 1'b1, 32'd0,
              asa_pkg::ST_BAD_ALIGN, 32'd0, 9'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 8'd1, 32'hFFFF_FFFF, 1'b1,
              32'd0, asa_pkg::ST_NO_SPACE, 32'd0, 9'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd16, 8'd8, 32'd0, 1'b1, 32'd8,
              asa_pkg::ST_OK, 32'd24, 9'd1);
      add_row(ROW_PLAIN, asa_pkg::KIND_DEALLOC, 32'd0, 8'd8, 32'd0, 1'b1, 32'd0,
              asa_pkg::ST_NOT_TOP, 32'd24, 9'd1);
      add_row(ROW_PLAIN, asa_pkg::KIND_DEALLOC, 32'd0, 8'd8, 32'd8, 1'b1, 32'd0,
              asa_pkg::ST_OK, 32'd0, 9'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd1, 8'd128, 32'd0, 1'b1, 32'd128,
              asa_pkg::ST_OK, 32'd129, 9'd1);
      // mixed alignments against the predictor
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd100, 8'd128, 32'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd3, 8'd16, 32'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd33, 8'd32, 32'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd5, 8'd64, 32'd0);
      add_row(ROW_FREE_TOP, asa_pkg::KIND_DEALLOC, 32'd0, 8'd1, 32'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd0, 8'd0, 32'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_DEALLOC, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
      // fill the region to the last byte, then one byte more
      add_row(ROW_FILL, asa_pkg::KIND_ALLOC, 32'd0, 8'd8, 32'd0);
      add_row(ROW_PLAIN, asa_pkg::KIND_ALLOC, 32'd1, 8'd1, 32'd0);
      for (int k = 0; k < 5; k++) begin
         add_row(ROW_FREE_TOP, asa_pkg::KIND_DEALLOC, 32'd0, 8'd4, 32'd0);
      end

      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // walk the directed list
      foreach (directed_rows[k]) begin
         w = directed_rows[k].word;
         if (directed_rows[k].mode == ROW_FREE_TOP) begin
            w.free_addr = newest_block();
         end else if (directed_rows[k].mode == ROW_FILL) begin
            w.size = region_capacity - used_bytes -
                     asa_pkg::SIZE_BITS'(header_pad(top_ptr, w.align));
         end
         send_word(w, directed_rows[k].typed, directed_rows[k].reply);
      end

      // random traffic at the reset region
      run_mixed(200);

      // region at the top of the address space, widest capacity
      write_reg(asa_pkg::CSR_BASE_ADDRESS, 32'hFFFF_FF00);
      write_reg(asa_pkg::CSR_CAPACITY_BYTES, 32'hFFFF_FFFF);
      run_mixed(200);

      // shrink the limit under live blocks; spare indexes change nothing
      write_reg(asa_pkg::CSR_CAPACITY_BYTES, 32'd64);
      write_reg(CSR_SPARE_LOW, 32'hFFFF_FFFF);
      write_reg(CSR_SPARE_HIGH, 32'h5A5A_A5A5);
      run_mixed(100);

      // one-byte capacity, without gaps
      idle_enable = 1'b0;
      write_reg(asa_pkg::CSR_BASE_ADDRESS, 32'h0000_1000);
      write_reg(asa_pkg::CSR_CAPACITY_BYTES, 32'd1);
      run_mixed(40);

      // random base, tight capacity
      idle_enable = 1'b1;
      write_reg(asa_pkg::CSR_BASE_ADDRESS, $urandom);
      write_reg(asa_pkg::CSR_CAPACITY_BYTES, 32'd400);
      run_mixed(120);

      // stack depth limit
      write_reg(asa_pkg::CSR_BASE_ADDRESS, 32'h8000_0000);
      write_reg(asa_pkg::CSR_CAPACITY_BYTES, 32'd65536);
      run_stack_fill();

      // closing stretch without gaps
      idle_enable = 1'b0;
      write_reg(asa_pkg::CSR_BASE_ADDRESS, 32'd0);
      run_mixed(200);

      drain();
      repeat (10) @(negedge clock);
      if (error_count == 0 && expected_replies.size() == 0) begin
         $display("** aligned_stack_allocator_core: PASSED **");
      end else begin
         $display("** aligned_stack_allocator_core: FAILED **");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/asa_pkg.sv
src/asa_stack_mem.sv
src/aligned_stack_allocator_core.sv
tb/sv/aligned_stack_allocator_core_tb.sv
